// ----- rtl/lrufr_pkg.sv -----
// Shared types and codes for the LRU frame replacement block.
package lrufr_pkg;

  localparam int unsigned FRAME_W = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned OCC_W   = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic FN_REF   = 1'b0;
  localparam logic FN_EVICT = 1'b1;

  localparam logic [STAT_W-1:0] ST_REF_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_VICTIM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic               func;
    logic [FRAME_W-1:0] frame_number;
  } lrufr_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] victim_frame;
    logic [STAT_W-1:0]  status;
    logic [OCC_W-1:0]   occupancy;
  } lrufr_out_t;

  typedef struct packed {
    logic               evict;
    logic               refer;
    logic               hit_any;
    logic [FRAME_W-1:0] key;
  } lrufr_ctrl_t;

endpackage

// ----- rtl/lrufr_cell.sv -----
// One recency slot: holds a frame, matches the key and shifts from its neighbor.
module lrufr_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic                         clk,
  input  lrufr_pkg::lrufr_ctrl_t       ctrl,
  input  logic [CW-1:0]                count,
  input  logic                         pre_hit,
  input  logic [lrufr_pkg::FRAME_W-1:0] nbr_frame,
  output logic [lrufr_pkg::FRAME_W-1:0] frame,
  output logic                         match
);

  logic [lrufr_pkg::FRAME_W-1:0] frame_r;
  logic [lrufr_pkg::FRAME_W-1:0] frame_nxt;
  logic                          slot_valid;
  logic                          is_tail;
  logic                          is_end;
  logic                          shift_en;
  logic                          load_en;

  assign slot_valid = CW'(IDX) < count;
  assign is_tail    = count == CW'(IDX + 1);
  assign is_end     = count == CW'(IDX);
  assign match      = slot_valid && (frame_r == ctrl.key);
  assign shift_en   = ctrl.evict || (ctrl.refer && pre_hit);
  assign load_en    = ctrl.refer && (ctrl.hit_any ? is_tail : is_end);

  always_comb begin
    frame_nxt = frame_r;
    if (load_en) begin
      frame_nxt = ctrl.key;
    end else if (shift_en) begin
      frame_nxt = nbr_frame;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frame = frame_r;

endmodule

// ----- rtl/lru_frame_replacement_top.sv -----
// Top level of the LRU frame replacement block: cell chain, control and output buffer.
//
// The input channel (in_valid, in_stall, in_data) takes one transaction per
// item: a reference to a frame or an eviction of the least recently used frame.
// The output channel (out_valid, out_stall, out_data) returns exactly one
// result transaction per item, carrying the victim, a status and the occupancy.
// The configuration port (cfg_we, cfg_wdata) sets the number of frames in use;
// write it only while no item is in flight.
// Each item is resolved by a chain of MAX_FRAMES cells that
// compare against the key in parallel and shift toward the least recent end.
// out_valid rises in the cycle after acceptance; the block takes one item
// per cycle while in_stall is low, as the cell chain is updated for each item.
// A result register and a skid register sit on the output, so one new item is
// still accepted while a result waits under out_stall; in_stall rises only
// when both hold results.
// Reset empties the list and sets the frame count to 64 in the same cycle;
// there is no clearing pass, and stored frames are never read before written.
module lru_frame_replacement_top #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lrufr_pkg::lrufr_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lrufr_pkg::lrufr_out_t  out_data,
  input  logic                   cfg_we,
  input  logic [lrufr_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LW = (CW > lrufr_pkg::CFG_W) ? CW : lrufr_pkg::CFG_W;

  logic [lrufr_pkg::CFG_W-1:0]   cfg_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [lrufr_pkg::FRAME_W-1:0] frames [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         match;
  logic [MAX_FRAMES-1:0]         pre_hit;
  lrufr_pkg::lrufr_ctrl_t        ctrl;
  lrufr_pkg::lrufr_out_t         res;
  lrufr_pkg::lrufr_out_t         out_r;
  lrufr_pkg::lrufr_out_t         skid_r;
  logic                          out_valid_r;
  logic                          skid_valid_r;
  logic                          accept;
  logic                          pop;
  logic                          in_range;
  logic                          is_evict;
  logic                          list_empty;

  assign accept     = in_valid && !in_stall;
  assign pop        = out_valid_r && !out_stall;
  assign is_evict   = in_data.func == lrufr_pkg::FN_EVICT;
  assign list_empty = count_r == '0;
  assign in_range   = (LW'(in_data.frame_number) < LW'(cfg_r)) &&
                      (LW'(in_data.frame_number) < LW'(MAX_FRAMES));

  always_comb begin
    pre_hit = match;
    for (int d = 1; d < MAX_FRAMES; d = d * 2) begin
      pre_hit = pre_hit | (pre_hit << d);
    end
  end

  always_comb begin
    ctrl.evict   = accept && is_evict && !list_empty;
    ctrl.refer   = accept && !is_evict && in_range;
    ctrl.hit_any = pre_hit[MAX_FRAMES-1];
    ctrl.key     = in_data.frame_number;
  end

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [lrufr_pkg::FRAME_W-1:0] nbr;
    if (i == MAX_FRAMES - 1) begin : g_last
      assign nbr = frames[i];
    end else begin : g_mid
      assign nbr = frames[i+1];
    end
    lrufr_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .pre_hit   (pre_hit[i]),
      .nbr_frame (nbr),
      .frame     (frames[i]),
      .match     (match[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.evict) begin
      count_nxt = count_r - CW'(1);
    end else if (ctrl.refer && !ctrl.hit_any && (count_r < CW'(MAX_FRAMES))) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    res.victim_frame = '0;
    res.occupancy    = lrufr_pkg::OCC_W'(count_nxt);
    if (is_evict) begin
      if (list_empty) begin
        res.status = lrufr_pkg::ST_EMPTY;
      end else begin
        res.status       = lrufr_pkg::ST_VICTIM;
        res.victim_frame = frames[0];
      end
    end else if (!in_range) begin
      res.status = lrufr_pkg::ST_RANGE;
    end else begin
      res.status = lrufr_pkg::ST_REF_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= lrufr_pkg::CFG_RESET;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (pop && !skid_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (accept && out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_r <= skid_r;
    end
    if (accept) begin
      if (out_valid_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/lrufr_checker.sv -----
// Port-level checker for the LRU frame replacement block, bound to the top level.
module lrufr_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input lrufr_pkg::lrufr_out_t out_data
);

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("Input stalled right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was dropped.");

  a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == lrufr_pkg::ST_EMPTY ||
                  out_data.status == lrufr_pkg::ST_RANGE) |->
    out_data.victim_frame == '0)
    else $error("Victim frame reported without an eviction.");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lrufr_pkg::ST_EMPTY |-> out_data.occupancy == '0)
    else $error("Empty eviction with nonzero occupancy.");

endmodule

bind lru_frame_replacement_top lrufr_checker u_lrufr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/lru_frame_replacement_top_test.sv -----
// Self-checking testbench for the LRU frame replacement block with a queue-based recency predictor.
`timescale 1ns / 1ps

module lru_frame_replacement_top_test;

  localparam int MAX_FRAMES = 64;
  localparam int LONG_HOLD = 48;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_COUNT = 10;
  localparam int ROW_COUNT = 26;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic                               func;
    logic [lrufr_pkg::FRAME_W-1:0]      frame;
    logic [lrufr_pkg::CFG_W-1:0]        cfg_value;
    bit                                 typed;
    logic [lrufr_pkg::FRAME_W-1:0]      exp_victim;
    logic [lrufr_pkg::STAT_W-1:0]       exp_status;
    logic [lrufr_pkg::OCC_W-1:0]        exp_occ;
  } directed_row_t;

  typedef struct {
    logic [lrufr_pkg::CFG_W-1:0] cfg_value;
    int                          items;
    int                          evict_pct;
  } phase_t;

  typedef struct {
    bit                    typed;
    lrufr_pkg::lrufr_out_t result;
  } row_hint_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  lrufr_pkg::lrufr_in_t        in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  lrufr_pkg::lrufr_out_t       out_data;
  logic                        cfg_we = 1'b0;
  logic [lrufr_pkg::CFG_W-1:0] cfg_wdata = '0;

  logic [lrufr_pkg::FRAME_W-1:0] recency_list[$];
  logic [lrufr_pkg::CFG_W-1:0]   frames_limit = lrufr_pkg::CFG_RESET;
  lrufr_pkg::lrufr_out_t         pending_results[$];
  row_hint_t                     row_hints[$];
  int unsigned                   fail_count = 0;

  bit          tx_gaps_on = 1'b0;
  bit          rx_gaps_on = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_taken = 1'b0;
  int unsigned rx_hold_left = 0;

  directed_row_t directed_rows[ROW_COUNT] = '{
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_EMPTY,    7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd1},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd63, 7'd0,   1'b1, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd2},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd2},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd21, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd42, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd63, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd63, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd0,  7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd42, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd21, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_EMPTY,    7'd0},
    '{ROW_CFG,  lrufr_pkg::FN_REF,   6'd0,  7'd1,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd1,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_RANGE,    7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd1},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd63, 7'd0,   1'b1, 6'd0, lrufr_pkg::ST_RANGE,    7'd1},
    '{ROW_CFG,  lrufr_pkg::FN_REF,   6'd0,  7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd0,  7'd0,   1'b1, 6'd0, lrufr_pkg::ST_RANGE,    7'd1},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd63, 7'd0,   1'b1, 6'd0, lrufr_pkg::ST_VICTIM,   7'd0},
    '{ROW_CFG,  lrufr_pkg::FN_REF,   6'd0,  7'd127, 1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd63, 7'd0,   1'b1, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd1},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd50, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_CFG,  lrufr_pkg::FN_REF,   6'd0,  7'd40,  1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_REF,   6'd50, 7'd0,   1'b1, 6'd0, lrufr_pkg::ST_RANGE,    7'd2},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd21, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0},
    '{ROW_ITEM, lrufr_pkg::FN_EVICT, 6'd42, 7'd0,   1'b0, 6'd0, lrufr_pkg::ST_REF_DONE, 7'd0}
  };

  phase_t phases[PHASE_COUNT] = '{
    '{7'd64, 200, 10}, '{7'd64, 150, 50}, '{7'd1, 60, 40}, '{7'd2, 60, 30},
    '{7'd127, 200, 15}, '{7'd0, 40, 30}, '{7'd17, 120, 30}, '{7'd64, 200, 8},
    '{7'd40, 100, 40}, '{7'd64, 120, 20}
  };

  lru_frame_replacement_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic lrufr_pkg::lrufr_out_t resolve_access(lrufr_pkg::lrufr_in_t item);
    lrufr_pkg::lrufr_out_t res;
    int                    lim;
    int                    hit_pos;
    res = '0;
    lim = (frames_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frames_limit);
    if (item.func == lrufr_pkg::FN_EVICT) begin
      if (recency_list.size() == 0) begin
        res.status = lrufr_pkg::ST_EMPTY;
      end else begin
        res.victim_frame = recency_list.pop_front();
        res.status = lrufr_pkg::ST_VICTIM;
      end
    end else if (int'(item.frame_number) >= lim) begin
      res.status = lrufr_pkg::ST_RANGE;
    end else begin
      res.status = lrufr_pkg::ST_REF_DONE;
      hit_pos = -1;
      foreach (recency_list[i]) begin
        if (hit_pos < 0 && recency_list[i] == item.frame_number) hit_pos = i;
      end
      if (hit_pos >= 0) recency_list.delete(hit_pos);
      if (recency_list.size() < MAX_FRAMES) recency_list.push_back(item.frame_number);
    end
    res.occupancy = lrufr_pkg::OCC_W'(recency_list.size());
    return res;
  endfunction

  always @(posedge clk) begin
    lrufr_pkg::lrufr_out_t predicted;
    lrufr_pkg::lrufr_out_t wanted;
    row_hint_t             hint;
    if (!rst_n) begin
      recency_list.delete();
      frames_limit = lrufr_pkg::CFG_RESET;
    end else begin
      if (cfg_we) frames_limit = cfg_wdata;
      if (in_valid && !in_stall) begin
        predicted = resolve_access(in_data);
        if (row_hints.size() != 0) begin
          hint = row_hints.pop_front();
          if (hint.typed) predicted = hint.result;
        end
        pending_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no item pending");
          fail_count++;
        end else begin
          wanted = pending_results.pop_front();
          if (out_data.victim_frame !== wanted.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", wanted.victim_frame,
                   out_data.victim_frame);
            fail_count++;
          end
          if (out_data.status !== wanted.status) begin
            $error("status: expected %0d, got %0d", wanted.status, out_data.status);
            fail_count++;
          end
          if (out_data.occupancy !== wanted.occupancy) begin
            $error("occupancy: expected %0d, got %0d", wanted.occupancy, out_data.occupancy);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      rx_hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
      rx_hold_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("lru_frame_replacement_top verification failed");
    $finish;
  end

  task automatic offer_access(input lrufr_pkg::lrufr_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_pause();
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_frames_limit(input logic [lrufr_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic lrufr_pkg::lrufr_in_t random_access(
      input logic [lrufr_pkg::CFG_W-1:0] cfg_value, input int evict_pct);
    lrufr_pkg::lrufr_in_t item;
    int                   lim;
    lim = (cfg_value > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_value);
    item.func = ($urandom_range(0, 99) < evict_pct) ? lrufr_pkg::FN_EVICT : lrufr_pkg::FN_REF;
    if (lim > 0 && $urandom_range(0, 99) < 85) begin
      item.frame_number = lrufr_pkg::FRAME_W'($urandom_range(0, lim - 1));
    end else begin
      item.frame_number = lrufr_pkg::FRAME_W'($urandom_range(0, 63));
    end
    return item;
  endfunction

  initial begin
    row_hint_t            hint;
    lrufr_pkg::lrufr_in_t item;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain_results();
        write_frames_limit(directed_rows[r].cfg_value);
      end else begin
        hint.typed = directed_rows[r].typed;
        hint.result.victim_frame = directed_rows[r].exp_victim;
        hint.result.status = directed_rows[r].exp_status;
        hint.result.occupancy = directed_rows[r].exp_occ;
        row_hints.push_back(hint);
        item.func = directed_rows[r].func;
        item.frame_number = directed_rows[r].frame;
        offer_access(item);
        sender_pause();
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      write_frames_limit(phases[p].cfg_value);
      for (int n = 0; n < phases[p].items; n++) begin
        if (p == PHASE_COUNT - 1) begin
          tx_gaps_on = 1'b0;
          rx_gaps_on = 1'b0;
        end else if (n % 40 == 0) begin
          tx_gaps_on = ($urandom_range(0, 2) != 0);
          rx_gaps_on = ($urandom_range(0, 2) != 0);
        end
        if (p == 0 && n == 60) long_hold_req = 1'b1;
        offer_access(random_access(phases[p].cfg_value, phases[p].evict_pct));
        sender_pause();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_frame_replacement_top verification clean");
    end else begin
      $display("lru_frame_replacement_top verification failed");
    end
    $finish;
  end

endmodule
